// ----- src/wireworld_grid_engine_macros.svh -----
// Assertion macros for the WireWorld grid engine.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef WIREWORLD_GRID_ENGINE_MACROS_SVH
`define WIREWORLD_GRID_ENGINE_MACROS_SVH

// A combinational condition that must hold at every clock edge.
`define WWG_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define WWG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/wwg_pkg.sv -----
// Shared types and codes for the WireWorld grid engine.
// No dependencies; imported by every module of the block.
package wwg_pkg;

    localparam int KIND_W = 3;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;

    typedef logic [1:0] t_cell;

    localparam t_cell CELL_EMPTY = 2'd0;
    localparam t_cell CELL_WIRE  = 2'd1;
    localparam t_cell CELL_HEAD  = 2'd2;
    localparam t_cell CELL_TAIL  = 2'd3;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_WRITE = 3'd0;
    localparam t_kind KIND_READ  = 3'd1;
    localparam t_kind KIND_STEP  = 3'd2;
    localparam t_kind KIND_CLEAR = 3'd3;
    localparam t_kind KIND_STRIP = 3'd4;

    typedef enum logic [1:0] {
        SWP_STEP,
        SWP_CLEAR,
        SWP_STRIP
    } t_sweep_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SWEEP,
        ST_LOOKUP,
        ST_RESULT
    } t_state;

endpackage

// ----- src/wwg_window.sv -----
// Sliding 3x3 neighborhood over the raster-ordered cell stream of a sweep,
// and the next-value rule for the center cell. Depends on wwg_pkg.
module wwg_window #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64,
    parameter int RW        = 6,
    parameter int CLW       = 6
) (
    input  logic                 i_clk,
    input  logic                 i_push,
    input  wwg_pkg::t_cell       i_push_cell,
    input  wwg_pkg::t_sweep_mode i_mode,
    input  logic [RW-1:0]        i_row,
    input  logic [CLW-1:0]       i_col,
    output wwg_pkg::t_cell       o_next_cell
);
    import wwg_pkg::*;

    localparam int LINE_LEN = 2 * GRID_COLS + 3;

    // Entry 0 is the newest cell; the center sits one row and one cell back.
    t_cell      r_line [LINE_LEN];
    t_cell      center;
    logic [7:0] head_bit;
    logic [3:0] heads;
    logic       up, down, left, right;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_line[0] <= i_push_cell;
            for (int i = 1; i < LINE_LEN; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    always_comb begin
        center = r_line[GRID_COLS + 1];
        up     = (i_row != '0);
        down   = (32'(i_row) < GRID_ROWS - 1);
        left   = (i_col != '0);
        right  = (32'(i_col) < GRID_COLS - 1);

        head_bit[0] = down  && right && (r_line[0] == CELL_HEAD);
        head_bit[1] = down           && (r_line[1] == CELL_HEAD);
        head_bit[2] = down  && left  && (r_line[2] == CELL_HEAD);
        head_bit[3] = right          && (r_line[GRID_COLS] == CELL_HEAD);
        head_bit[4] = left           && (r_line[GRID_COLS + 2] == CELL_HEAD);
        head_bit[5] = up    && right && (r_line[2 * GRID_COLS] == CELL_HEAD);
        head_bit[6] = up             && (r_line[2 * GRID_COLS + 1] == CELL_HEAD);
        head_bit[7] = up    && left  && (r_line[2 * GRID_COLS + 2] == CELL_HEAD);

        heads = '0;
        for (int i = 0; i < 8; i++) begin
            heads = heads + 4'(head_bit[i]);
        end

        case (i_mode)
            SWP_STEP: begin
                case (center)
                    CELL_HEAD: o_next_cell = CELL_TAIL;
                    CELL_TAIL: o_next_cell = CELL_WIRE;
                    CELL_WIRE: o_next_cell = (heads == 4'd1 || heads == 4'd2) ?
                                             CELL_HEAD : CELL_WIRE;
                    default:   o_next_cell = CELL_EMPTY;
                endcase
            end
            SWP_STRIP: o_next_cell = (center != CELL_EMPTY) ? CELL_WIRE : CELL_EMPTY;
            default:   o_next_cell = CELL_EMPTY;
        endcase
    end

endmodule

// ----- src/wireworld_grid_engine.sv -----
// Cell write: a write state, then the lookup and result states; cell read: lookup and result.
// Step, clear and strip: one sweep over the grid, set by one cell read per cycle and the
// window lead, followed by the lookup and result states.
// One command is in progress at a time; the next is accepted while a result waits.
// After reset the grid is cleared by the same sweep, during which no command is accepted.
module wireworld_grid_engine #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [wwg_pkg::KIND_W-1:0]  i_kind,
    input  logic [wwg_pkg::ROW_W-1:0]   i_row,
    input  logic [wwg_pkg::COL_W-1:0]   i_col,
    input  wwg_pkg::t_cell              i_new_cell,
    output logic                        o_valid,
    input  logic                        i_stall,
    output wwg_pkg::t_cell              o_cell_value
);
    import wwg_pkg::*;

    localparam int N    = GRID_ROWS * GRID_COLS;
    localparam int AW   = $clog2(N);
    localparam int CNTW = $clog2(N + 1);
    localparam int RW   = $clog2(GRID_ROWS);
    localparam int CLW  = $clog2(GRID_COLS);
    localparam int LEAD = GRID_COLS + 3;
    localparam int LW   = $clog2(LEAD + 1);

    // Grid memory, one read and one write port, registered read data.
    t_cell mem [N];
    t_cell r_rdata;
    logic          mem_re, mem_we;
    logic [AW-1:0] mem_raddr, mem_waddr;
    t_cell         mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Control state.
    t_state        r_state, n_state;
    t_sweep_mode   r_mode, n_mode;
    logic          r_boot, n_boot;
    logic [CNTW-1:0] r_rd_idx, n_rd_idx;
    logic          r_rd_vld, n_rd_vld;
    logic [LW-1:0] r_lead, n_lead;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [RW-1:0] r_wr_row, n_wr_row;
    logic [CLW-1:0] r_wr_col, n_wr_col;
    logic          r_out_vld, n_out_vld;
    t_cell         r_out_cell, n_out_cell;

    // Command payload.
    logic [AW-1:0] r_addr;
    logic          r_inside;
    t_cell         r_new_cell;

    logic          accept;
    logic          in_inside;
    logic [31:0]   in_addr;
    logic          push;
    t_cell         push_cell;
    t_cell         win_next;

    assign o_stall      = (r_state != ST_IDLE);
    assign accept       = i_valid && !o_stall;
    assign o_valid      = r_out_vld;
    assign o_cell_value = r_out_cell;
    assign in_inside    = (32'(i_row) < GRID_ROWS) && (32'(i_col) < GRID_COLS);
    assign in_addr      = 32'(i_row) * GRID_COLS + 32'(i_col);
    assign push_cell    = r_rd_vld ? r_rdata : CELL_EMPTY;

    wwg_window #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .RW        (RW),
        .CLW       (CLW)
    ) u_window (
        .i_clk       (i_clk),
        .i_push      (push),
        .i_push_cell (push_cell),
        .i_mode      (r_mode),
        .i_row       (r_wr_row),
        .i_col       (r_wr_col),
        .o_next_cell (win_next)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr     <= in_addr[AW-1:0];
            r_inside   <= in_inside;
            r_new_cell <= i_new_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_SWEEP;
            r_mode    <= SWP_CLEAR;
            r_boot    <= 1'b1;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_lead    <= '0;
            r_wr_idx  <= '0;
            r_wr_row  <= '0;
            r_wr_col  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_boot    <= n_boot;
            r_rd_idx  <= n_rd_idx;
            r_rd_vld  <= n_rd_vld;
            r_lead    <= n_lead;
            r_wr_idx  <= n_wr_idx;
            r_wr_row  <= n_wr_row;
            r_wr_col  <= n_wr_col;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cell <= n_out_cell;
    end

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_boot     = r_boot;
        n_rd_idx   = r_rd_idx;
        n_rd_vld   = 1'b0;
        n_lead     = r_lead;
        n_wr_idx   = r_wr_idx;
        n_wr_row   = r_wr_row;
        n_wr_col   = r_wr_col;
        n_out_vld  = r_out_vld;
        n_out_cell = r_out_cell;
        mem_re     = 1'b0;
        mem_raddr  = r_rd_idx[AW-1:0];
        mem_we     = 1'b0;
        mem_waddr  = r_wr_idx;
        mem_wdata  = win_next;
        push       = 1'b0;

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_rd_idx = '0;
                    n_lead   = '0;
                    n_wr_idx = '0;
                    n_wr_row = '0;
                    n_wr_col = '0;
                    case (i_kind)
                        KIND_WRITE: n_state = ST_WRITE;
                        KIND_STEP: begin
                            n_state = ST_SWEEP;
                            n_mode  = SWP_STEP;
                        end
                        KIND_CLEAR: begin
                            n_state = ST_SWEEP;
                            n_mode  = SWP_CLEAR;
                        end
                        KIND_STRIP: begin
                            n_state = ST_SWEEP;
                            n_mode  = SWP_STRIP;
                        end
                        default: n_state = ST_LOOKUP;
                    endcase
                end
            end
            ST_WRITE: begin
                mem_we    = r_inside;
                mem_waddr = r_addr;
                mem_wdata = r_new_cell;
                n_state   = ST_LOOKUP;
            end
            ST_SWEEP: begin
                // Reads run GRID_COLS+3 cells ahead of the write-back, so the
                // window always sees old values and never a fresh one.
                push = 1'b1;
                if (r_rd_idx < CNTW'(N)) begin
                    mem_re   = 1'b1;
                    n_rd_vld = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_lead != LW'(LEAD)) begin
                    n_lead = r_lead + 1'b1;
                end else begin
                    mem_we   = 1'b1;
                    n_wr_idx = r_wr_idx + 1'b1;
                    if (32'(r_wr_col) == GRID_COLS - 1) begin
                        n_wr_col = '0;
                        n_wr_row = r_wr_row + 1'b1;
                    end else begin
                        n_wr_col = r_wr_col + 1'b1;
                    end
                    if (r_wr_idx == AW'(N - 1)) begin
                        n_state = r_boot ? ST_IDLE : ST_LOOKUP;
                        n_boot  = 1'b0;
                    end
                end
            end
            ST_LOOKUP: begin
                mem_re    = 1'b1;
                mem_raddr = r_addr;
                n_state   = ST_RESULT;
            end
            ST_RESULT: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld  = 1'b1;
                    n_out_cell = r_inside ? r_rdata : CELL_EMPTY;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `include "wireworld_grid_engine_macros.svh"

    `WWG_ASSERT_ALWAYS(a_sweep_write_behind_read,
        !(r_state == ST_SWEEP && mem_we) || ({1'b0, r_wr_idx} < r_rd_idx),
        "sweep write-back overtook the read pointer")
    `WWG_ASSERT_NEXT(a_accept_leaves_idle, accept, r_state != ST_IDLE,
        "accepted command did not start")
    `WWG_ASSERT_NEXT(a_result_waits, r_state == ST_RESULT && r_out_vld && i_stall,
        r_state == ST_RESULT && r_out_vld, "result overwrote a pending transaction")

endmodule

// ----- sim/wwg_cell_checker.sv -----
// Scoreboard for the WireWorld grid engine: keeps its own copy of the grid, predicts
// the cell value each command returns and compares it with every result transaction.
// Depends on wwg_pkg only.
module wwg_cell_checker #(
    parameter int GRID_COLS = 64,
    parameter int GRID_ROWS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  logic                        i_cmd_stall,
    input  logic [wwg_pkg::KIND_W-1:0]  i_kind,
    input  logic [wwg_pkg::ROW_W-1:0]   i_row,
    input  logic [wwg_pkg::COL_W-1:0]   i_col,
    input  wwg_pkg::t_cell              i_new_cell,
    input  logic                        i_res_valid,
    input  logic                        i_res_stall,
    input  wwg_pkg::t_cell              i_cell_value,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);
    import wwg_pkg::*;

    typedef struct {
        t_kind              kind;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        t_cell              value;
    } t_cell_due;

    t_cell     board [GRID_ROWS][GRID_COLS];
    t_cell_due cells_due [$];

    function automatic int heads_around(int r, int c);
        int n;
        int dr;
        int dc;
        n = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                // Cells beyond the border count as non-heads; there is no wrap.
                if (!(dr == 0 && dc == 0) && r + dr >= 0 && r + dr < GRID_ROWS &&
                        c + dc >= 0 && c + dc < GRID_COLS &&
                        board[r + dr][c + dc] == CELL_HEAD) begin
                    n++;
                end
            end
        end
        return n;
    endfunction

    function automatic void advance_generation();
        t_cell nxt [GRID_ROWS][GRID_COLS];
        int heads;
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
                case (board[r][c])
                    CELL_EMPTY: nxt[r][c] = CELL_EMPTY;
                    CELL_HEAD:  nxt[r][c] = CELL_TAIL;
                    CELL_TAIL:  nxt[r][c] = CELL_WIRE;
                    default: begin
                        heads = heads_around(r, c);
                        nxt[r][c] = (heads == 1 || heads == 2) ? CELL_HEAD : CELL_WIRE;
                    end
                endcase
            end
        end
        board = nxt;
    endfunction

    function automatic void fill_board(bit strip_only);
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
                if (!strip_only) begin
                    board[r][c] = CELL_EMPTY;
                end else if (board[r][c] != CELL_EMPTY) begin
                    board[r][c] = CELL_WIRE;
                end
            end
        end
    endfunction

    function automatic t_cell run_command(t_kind k, logic [ROW_W-1:0] r,
                                          logic [COL_W-1:0] c, t_cell v);
        bit on_grid;
        on_grid = (r < GRID_ROWS) && (c < GRID_COLS);
        case (k)
            KIND_WRITE: begin
                if (on_grid) begin
                    board[r][c] = v;
                end
            end
            KIND_STEP:  advance_generation();
            KIND_CLEAR: fill_board(1'b0);
            KIND_STRIP: fill_board(1'b1);
            default: ;
        endcase
        return on_grid ? board[r][c] : CELL_EMPTY;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_cell_due item;
        if (!i_rst_n) begin
            fill_board(1'b0);
            cells_due.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            // The result side is handled first, so a result transaction at the same edge
            // can never be matched against the command accepted at that edge.
            if (i_res_valid && !i_res_stall) begin
                if (cells_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result transaction with nothing expected, got %0d",
                             $time, i_cell_value);
                end else begin
                    item = cells_due.pop_front();
                    o_checked++;
                    if (i_cell_value !== item.value) begin
                        o_fail_count++;
                        $display("%0t: kind %0d at (%0d,%0d): cell_value expected %0d got %0d",
                                 $time, item.kind, item.row, item.col, item.value,
                                 i_cell_value);
                    end
                end
            end
            if (i_cmd_valid && !i_cmd_stall) begin
                item.kind = i_kind;
                item.row = i_row;
                item.col = i_col;
                item.value = run_command(i_kind, i_row, i_col, i_new_cell);
                cells_due.push_back(item);
            end
        end
        o_pending = cells_due.size();
    end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the WireWorld grid engine: sends command transactions with random
// idling and receiver stalls, then gives the verdict.
// Depends on wwg_pkg, wireworld_grid_engine and wwg_cell_checker.
module tb;
    import wwg_pkg::*;

    localparam int GRID_COLS     = 64;
    localparam int GRID_ROWS     = 64;
    localparam int RANDOM_ITEMS  = 100;
    localparam int SWEEP_BUDGET  = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int EDGE_ROW      = GRID_ROWS - 1;
    localparam int EDGE_COL      = GRID_COLS - 1;

    // Kinds with no function; the block treats them as reads.
    localparam t_kind KIND_SPARE_5 = 3'd5;
    localparam t_kind KIND_SPARE_6 = 3'd6;
    localparam t_kind KIND_SPARE_7 = 3'd7;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               i_stall    = 1'b0;
    t_kind              i_kind     = KIND_READ;
    logic [ROW_W-1:0]   i_row      = '0;
    logic [COL_W-1:0]   i_col      = '0;
    t_cell              i_new_cell = CELL_EMPTY;
    logic               o_stall;
    logic               o_valid;
    t_cell              o_cell_value;

    int fail_count;
    int pending;
    int checked;
    int sent        = 0;
    int sweeps      = 0;
    int target      = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    int calm_left   = 0;
    bit no_gaps     = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;

    wireworld_grid_engine #(
        .GRID_COLS(GRID_COLS),
        .GRID_ROWS(GRID_ROWS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_new_cell   (i_new_cell),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_value (o_cell_value)
    );

    wwg_cell_checker #(
        .GRID_COLS(GRID_COLS),
        .GRID_ROWS(GRID_ROWS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_valid),
        .i_cmd_stall  (o_stall),
        .i_kind       (i_kind),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_new_cell   (i_new_cell),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_cell_value (o_cell_value),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("FAIL wireworld_grid_engine");
            $finish;
        end
    end

    // Receiver: short random stalls, calm stretches, and one long hold-off so that
    // the block fills up and has to stall its command input.
    always @(negedge i_clk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES;
        end else if (stall_left == 0) begin
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 99) < 3) begin
                calm_left = $urandom_range(40, 200);
            end else if ($urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
        end
        i_stall <= (stall_left > 0);
        if (stall_left > 0) begin
            stall_left--;
        end
    end

    function automatic int sender_gap();
        int x;
        x = $urandom_range(0, 99);
        if (no_gaps || x < 45) begin
            return 0;
        end else if (x < 85) begin
            return $urandom_range(1, 3);
        end else if (x < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_cell random_cell();
        int x;
        x = $urandom_range(0, 99);
        if (x < 50) begin
            return CELL_WIRE;
        end else if (x < 70) begin
            return CELL_HEAD;
        end else if (x < 82) begin
            return CELL_TAIL;
        end
        return CELL_EMPTY;
    endfunction

    task automatic send_cmd(input t_kind k, input int r, input int c, input t_cell v);
        int gap;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= k;
        i_row <= ROW_W'(r);
        i_col <= COL_W'(c);
        i_new_cell <= v;
        do @(posedge i_clk); while (o_stall);
        sent++;
        if (k == KIND_STEP || k == KIND_CLEAR || k == KIND_STRIP) begin
            sweeps++;
        end
    endtask

    // Whole-grid commands each cost a full sweep, so their number is capped.
    task automatic send_sweep(input t_kind k, input int r, input int c);
        send_cmd((sweeps < SWEEP_BUDGET) ? k : KIND_READ, r, c, random_cell());
    endtask

    task automatic send_any();
        t_kind k;
        k = t_kind'($urandom_range(0, 7));
        if (k == KIND_STEP || k == KIND_CLEAR || k == KIND_STRIP) begin
            send_sweep(k, $urandom_range(0, EDGE_ROW), $urandom_range(0, EDGE_COL));
        end else begin
            send_cmd(k, $urandom_range(0, EDGE_ROW), $urandom_range(0, EDGE_COL),
                     t_cell'($urandom_range(0, 3)));
        end
    endtask

    // One episode works on an 8x8 window: draw a pattern, run a few generations and
    // read some of its cells back. A minority of episodes are unstructured noise.
    task automatic run_episode();
        int r0;
        int c0;
        int i;
        int len;
        int rr;
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) < 3) begin
            r0 = $urandom_range(0, 1) * (GRID_ROWS - 8);
            c0 = $urandom_range(0, 1) * (GRID_COLS - 8);
        end else begin
            r0 = $urandom_range(0, GRID_ROWS - 8);
            c0 = $urandom_range(0, GRID_COLS - 8);
        end
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(4, 8)) send_any();
        end else begin
            if ($urandom_range(0, 4) == 0) begin
                send_sweep(KIND_CLEAR, r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7));
            end
            if ($urandom_range(0, 1) == 1) begin
                // A conductor line carrying one pulse: tail, head, then wire.
                rr = r0 + $urandom_range(0, 7);
                len = $urandom_range(4, 8);
                for (i = 0; i < len; i++) begin
                    send_cmd(KIND_WRITE, rr, c0 + i,
                             (i == 0) ? CELL_TAIL : (i == 1) ? CELL_HEAD : CELL_WIRE);
                end
            end
            repeat ($urandom_range(3, 10)) begin
                send_cmd(KIND_WRITE, r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7),
                         random_cell());
            end
            repeat ($urandom_range(1, 3)) begin
                send_sweep(KIND_STEP, r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7));
                repeat ($urandom_range(1, 3)) begin
                    send_cmd(KIND_READ, r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7),
                             random_cell());
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                send_sweep(KIND_STRIP, r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7));
                send_cmd(KIND_READ, r0 + $urandom_range(0, 7), c0 + $urandom_range(0, 7),
                         random_cell());
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: corners and borders, all cell values, every kind.
        send_cmd(KIND_READ, 0, 0, CELL_EMPTY);
        send_cmd(KIND_WRITE, 0, 0, CELL_HEAD);
        send_cmd(KIND_WRITE, 0, 1, CELL_WIRE);
        send_cmd(KIND_WRITE, 1, 1, CELL_WIRE);
        send_cmd(KIND_WRITE, EDGE_ROW, EDGE_COL, CELL_TAIL);
        send_cmd(KIND_WRITE, EDGE_ROW, EDGE_COL - 1, CELL_HEAD);
        send_cmd(KIND_WRITE, EDGE_ROW - 1, EDGE_COL - 1, CELL_WIRE);
        send_cmd(KIND_WRITE, 0, EDGE_COL, CELL_WIRE);
        send_cmd(KIND_WRITE, EDGE_ROW, 0, CELL_WIRE);
        send_cmd(KIND_WRITE, EDGE_ROW, 0, CELL_EMPTY);
        // A conductor with three head neighbors must stay a conductor.
        send_cmd(KIND_WRITE, 9, 9, CELL_HEAD);
        send_cmd(KIND_WRITE, 9, 10, CELL_HEAD);
        send_cmd(KIND_WRITE, 9, 11, CELL_HEAD);
        send_cmd(KIND_WRITE, 10, 10, CELL_WIRE);
        send_sweep(KIND_STEP, 10, 10);
        send_cmd(KIND_READ, 0, 1, CELL_EMPTY);
        send_cmd(KIND_READ, 1, 1, CELL_EMPTY);
        send_sweep(KIND_STEP, EDGE_ROW - 1, EDGE_COL - 1);
        send_cmd(KIND_SPARE_5, EDGE_ROW, EDGE_COL, CELL_HEAD);
        send_cmd(KIND_SPARE_6, 0, EDGE_COL, CELL_TAIL);
        send_cmd(KIND_SPARE_7, 21, 42, CELL_WIRE);
        send_sweep(KIND_STRIP, EDGE_ROW, EDGE_COL - 1);
        send_cmd(KIND_READ, 0, 0, CELL_EMPTY);
        send_sweep(KIND_CLEAR, 0, 1);
        send_cmd(KIND_READ, EDGE_ROW, EDGE_COL, CELL_EMPTY);

        // Long receiver hold-off while commands keep coming back to back.
        target = sent + RANDOM_ITEMS;
        hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (10) begin
            send_cmd(($urandom_range(0, 1) == 1) ? KIND_WRITE : KIND_READ,
                     $urandom_range(30, 33), $urandom_range(30, 33), random_cell());
        end

        while (sent < target) begin
            run_episode();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("Run: %0d commands sent, %0d of them whole-grid sweeps, %0d results compared.",
                 sent, sweeps, checked);
        $display("Grid corners, pulses on wires, unused kinds and a long result hold-off were hit.");
        if (fail_count == 0) begin
            $display("PASS wireworld_grid_engine");
        end else begin
            $display("FAIL wireworld_grid_engine");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/wwg_pkg.sv
src/wwg_window.sv
src/wireworld_grid_engine.sv
sim/wwg_cell_checker.sv
sim/tb.sv
